// ===== design/gbf_pkg.sv =====
package gbf_pkg;

    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 128;
    localparam int VW          = 6;   // vertex index width
    localparam int EW          = 7;   // edge index width
    localparam int CW          = 8;   // edge count / cursor width
    localparam int DW          = 7;   // discovery order width
    localparam int SW          = 7;   // stack depth width

    typedef struct packed {
        logic [5:0] edge_from_vertex;
        logic [5:0] edge_to_vertex;
        logic       last_edge;
    } in_word_t;

    typedef struct packed {
        logic [5:0] bridge_parent;
        logic [5:0] bridge_child;
        logic       bridge_valid;
        logic       last_result;
        logic       edges_dropped;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic store_edge;    // write input edge to store
        logic set_overflow;
        logic search_init;   // clear marks, load root frame
        logic scan_issue;    // read edge at cursor of top frame
        logic scan_eval;     // evaluate registered edge read
        logic back_edge;     // fold registered discovery order into top low
        logic pop_frame;     // drop top, start parent frame read
        logic pop_merge;     // parent frame becomes top, low merged
        logic take_bridge;   // found bridge becomes the held bridge
        logic clear_job;     // empty store after job
        logic emit;          // load output register
        logic emit_none;     // output is the empty result
        logic emit_final;    // output is the last word of the graph
    } gbf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic store_full;
        logic cursor_done;   // cursor reached edges_loaded
        logic at_root;       // only the root frame is on the stack
        logic need_back;     // neighbor already visited and not the parent
        logic is_bridge;     // last merge made a bridge
        logic have_bridge;   // a bridge word is held back
    } gbf_stat_t;

endpackage

// ===== design/gbf_datapath.sv =====
module gbf_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          vertex_count,
    input  gbf_pkg::in_word_t   in_word,
    input  gbf_pkg::gbf_cmd_t   cmd,
    output gbf_pkg::gbf_stat_t  stat,
    output gbf_pkg::out_word_t  res_word
);
    import gbf_pkg::*;

    // one stack frame; low and discovery order of a vertex travel with its frame
    typedef struct packed {
        logic [VW-1:0] v;
        logic [VW-1:0] p;
        logic [CW-1:0] cur;
        logic [DW-1:0] low;
        logic [DW-1:0] disc;
    } frame_t;

    logic [VW-1:0] efirst_mem [MaxEdges];
    logic [VW-1:0] esecond_mem [MaxEdges];
    logic [VW-1:0] rd_a_reg, rd_b_reg;

    logic [DW-1:0] disc_mem [MaxVertices];
    logic [DW-1:0] disc_rd_reg;
    frame_t        stk_mem [MaxVertices];
    frame_t        frame_rd_reg;
    frame_t        top_reg, top_next;

    logic [MaxVertices-1:0] visited_reg, visited_next;
    logic [CW-1:0] loaded_reg;
    logic          ovf_reg;
    logic [SW-1:0] depth_reg, depth_next;
    logic [DW-1:0] clock_reg;
    logic          bridge_reg, have_reg;
    logic [VW-1:0] br_p_reg, br_c_reg;
    logic [VW-1:0] pend_p_reg, pend_c_reg;
    logic [6:0]    vc_eff;

    logic [VW-1:0] save_idx, pop_idx;
    logic          in_a, in_b, hit, seen_nb, do_push, pop_bridge;
    logic [VW-1:0] nb;
    logic [DW-1:0] merged_low;

    assign vc_eff     = (vertex_count == 7'd0) ? 7'd1 :
                        (vertex_count > 7'(MaxVertices)) ? 7'(MaxVertices) : vertex_count;
    assign save_idx   = VW'(depth_reg - SW'(1));
    assign pop_idx    = VW'(depth_reg - SW'(2));
    assign in_a       = {1'b0, rd_a_reg} < vc_eff;
    assign in_b       = {1'b0, rd_b_reg} < vc_eff;
    assign hit        = in_a && in_b && (rd_a_reg == top_reg.v || rd_b_reg == top_reg.v);
    assign nb         = (rd_a_reg == top_reg.v) ? rd_b_reg : rd_a_reg;
    assign seen_nb    = visited_reg[nb];
    assign do_push    = cmd.scan_eval && hit && !seen_nb && depth_reg < SW'(MaxVertices);
    assign pop_bridge = top_reg.low > frame_rd_reg.disc;
    assign merged_low = (top_reg.low < frame_rd_reg.low) ? top_reg.low : frame_rd_reg.low;

    assign stat.store_full  = loaded_reg == CW'(MaxEdges);
    assign stat.cursor_done = top_reg.cur >= loaded_reg;
    assign stat.at_root     = depth_reg == SW'(1);
    assign stat.need_back   = hit && seen_nb && (depth_reg == SW'(1) || nb != top_reg.p);
    assign stat.is_bridge   = bridge_reg;
    assign stat.have_bridge = have_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store_edge)
        begin
            efirst_mem[EW'(loaded_reg)]  <= in_word.edge_from_vertex;
            esecond_mem[EW'(loaded_reg)] <= in_word.edge_to_vertex;
        end
        rd_a_reg <= efirst_mem[EW'(top_reg.cur)];
        rd_b_reg <= esecond_mem[EW'(top_reg.cur)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
            disc_mem[0] <= DW'(1);
        else if (do_push)
            disc_mem[nb] <= clock_reg;
        disc_rd_reg <= disc_mem[nb];
    end

    // saved frames below the top; the parent frame is read while the top pops
    always_ff @(posedge clk)
    begin
        if (do_push)
            stk_mem[save_idx] <= top_reg;
        frame_rd_reg <= stk_mem[pop_idx];
    end

    always_comb
    begin
        top_next     = top_reg;
        visited_next = visited_reg;
        depth_next   = depth_reg;
        if (cmd.search_init)
        begin
            top_next        = '0;
            top_next.low    = DW'(1);
            top_next.disc   = DW'(1);
            visited_next    = '0;
            visited_next[0] = 1'b1;
            depth_next      = SW'(1);
        end
        else if (cmd.scan_issue)
        begin
            top_next.cur = top_reg.cur + CW'(1);
        end
        else if (do_push)
        begin
            top_next.v       = nb;
            top_next.p       = top_reg.v;
            top_next.cur     = '0;
            top_next.low     = clock_reg;
            top_next.disc    = clock_reg;
            visited_next[nb] = 1'b1;
            depth_next       = depth_reg + SW'(1);
        end
        else if (cmd.back_edge)
        begin
            if (disc_rd_reg < top_reg.low)
                top_next.low = disc_rd_reg;
        end
        else if (cmd.pop_frame)
        begin
            depth_next = depth_reg - SW'(1);
        end
        else if (cmd.pop_merge)
        begin
            top_next     = frame_rd_reg;
            top_next.low = merged_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg  <= '0;
            ovf_reg     <= 1'b0;
            depth_reg   <= '0;
            clock_reg   <= DW'(1);
            visited_reg <= '0;
            top_reg     <= '0;
            bridge_reg  <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
            depth_reg   <= depth_next;
            top_reg     <= top_next;
            if (cmd.clear_job)
                loaded_reg <= '0;
            else if (cmd.store_edge)
                loaded_reg <= loaded_reg + CW'(1);
            if (cmd.clear_job)
                ovf_reg <= 1'b0;
            else if (cmd.set_overflow)
                ovf_reg <= 1'b1;
            if (cmd.search_init)
            begin
                clock_reg  <= DW'(2);
                have_reg   <= 1'b0;
                bridge_reg <= 1'b0;
            end
            else
            begin
                if (do_push)
                    clock_reg <= clock_reg + DW'(1);
                if (cmd.pop_merge)
                    bridge_reg <= pop_bridge;
                if (cmd.take_bridge)
                    have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop_merge)
        begin
            br_p_reg <= top_reg.p;
            br_c_reg <= top_reg.v;
        end
        if (cmd.take_bridge)
        begin
            pend_p_reg <= br_p_reg;
            pend_c_reg <= br_c_reg;
        end
        if (cmd.emit)
        begin
            res_word.bridge_parent <= cmd.emit_none ? '0 : pend_p_reg;
            res_word.bridge_child  <= cmd.emit_none ? '0 : pend_c_reg;
            res_word.bridge_valid  <= !cmd.emit_none;
            res_word.last_result   <= cmd.emit_final;
            res_word.edges_dropped <= ovf_reg;
        end
    end

endmodule

// ===== design/gbf_control.sv =====
module gbf_control
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_stall,
    input  gbf_pkg::gbf_stat_t stat,
    output gbf_pkg::gbf_cmd_t  cmd
);
    import gbf_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_BACK  = 3'd4;
    localparam logic [2:0] S_POP   = 3'd5;
    localparam logic [2:0] S_CHECK = 3'd6;
    localparam logic [2:0] S_WAIT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       accept, out_free;

    assign in_stall  = state_reg != S_LOAD;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.store_edge   = !stat.store_full;
                    cmd.set_overflow = stat.store_full;
                    if (in_last)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.search_init = 1'b1;
                state_next      = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (stat.cursor_done)
                begin
                    cmd.pop_frame = 1'b1;
                    state_next    = stat.at_root ? S_WAIT : S_POP;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = stat.need_back ? S_BACK : S_ISSUE;
            end
            S_BACK:
            begin
                cmd.back_edge = 1'b1;
                state_next    = S_ISSUE;
            end
            S_POP:
            begin
                cmd.pop_merge = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                // a new bridge sends the held one to the output; while the output is not free the search waits
                if (!stat.is_bridge)
                    state_next = S_ISSUE;
                else if (!stat.have_bridge)
                begin
                    cmd.take_bridge = 1'b1;
                    state_next      = S_ISSUE;
                end
                else if (out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.take_bridge = 1'b1;
                    ov_next         = 1'b1;
                    state_next      = S_ISSUE;
                end
            end
            S_WAIT:
            begin
                // final word: the held bridge, or the empty word
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_none  = !stat.have_bridge;
                    cmd.emit_final = 1'b1;
                    ov_next        = 1'b1;
                    cmd.clear_job  = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== design/graph_bridge_finder_unit.sv =====
// Loading: one edge word per cycle. After the last edge the input stalls for the search,
// which scans the stored edges from every reached vertex, and while a bridge word waits
// on out_stall.
// Each bridge word is held until the next is found, so the final word carries last_result.
// One graph at a time; a stalled output word holds the search.
// rst_n is asynchronous: edge store empty, vertex_count = 64, output idle.
module graph_bridge_finder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gbf_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gbf_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data
);
    import gbf_pkg::*;

    logic [6:0] vc_reg;
    gbf_cmd_t   cmd;
    gbf_stat_t  stat;
    out_word_t  res_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 7'd64;
        end
        else
        begin
            if (cfg_we)
                vc_reg <= cfg_data;
        end
    end

    gbf_control u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_last   (in_data.last_edge),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gbf_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vc_reg),
        .in_word      (in_data),
        .cmd          (cmd),
        .stat         (stat),
        .res_word     (res_word)
    );

    assign out_data = res_word;

endmodule

// ===== tb/sv/tb_graph_bridge_finder_unit.sv =====
module tb_graph_bridge_finder_unit;
    import gbf_pkg::*;

    localparam int CycleLimit = 4000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;
    logic      cfg_we;
    logic [6:0] cfg_data;

    graph_bridge_finder_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // predictor state
    logic [5:0] graph_from [MaxEdges];
    logic [5:0] graph_to [MaxEdges];
    int         graph_edges;
    bit         graph_overflow;
    int         vertex_limit;

    out_word_t  bridge_queue[$];
    int         mismatch_count;
    int         cycle_count;
    bit         stall_enable;
    int         out_hold;
    int         out_draw;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Tarjan bridge search, iterative, mirrors the block's walk order.
    task automatic find_bridges();
        int         vc;
        bit         seen [MaxVertices];
        int         disc [MaxVertices];
        int         low [MaxVertices];
        int         st_v [MaxVertices];
        int         st_p [MaxVertices];
        int         st_c [MaxVertices];
        int         depth;
        int         clock_now;
        int         found_cnt;
        int         t, v, e, nb, p;
        bit         found;
        out_word_t  w;
        begin
            vc = (vertex_limit < 1) ? 1 : (vertex_limit > MaxVertices ? MaxVertices : vertex_limit);
            foreach (seen[i]) seen[i] = 0;
            clock_now = 1;
            depth = 0;
            found_cnt = 0;
            seen[0] = 1; disc[0] = 1; low[0] = 1; clock_now = 2;
            st_v[0] = 0; st_p[0] = 0; st_c[0] = 0; depth = 1;
            while (depth > 0)
            begin
                t = depth - 1;
                v = st_v[t];
                e = st_c[t];
                found = 0;
                nb = 0;
                while (e < graph_edges && !found)
                begin
                    int a, b;
                    a = graph_from[e];
                    b = graph_to[e];
                    e++;
                    if (a >= vc || b >= vc) continue;
                    if (a == v) begin nb = b; found = 1; end
                    else if (b == v) begin nb = a; found = 1; end
                end
                st_c[t] = e;
                if (found)
                begin
                    if (!seen[nb])
                    begin
                        if (depth < MaxVertices)
                        begin
                            seen[nb] = 1; disc[nb] = clock_now; low[nb] = clock_now;
                            clock_now++;
                            st_v[depth] = nb; st_p[depth] = v; st_c[depth] = 0;
                            depth++;
                        end
                    end
                    else if (t == 0 || nb != st_p[t])
                    begin
                        if (disc[nb] < low[v]) low[v] = disc[nb];
                    end
                end
                else
                begin
                    depth--;
                    if (t > 0)
                    begin
                        p = st_p[t];
                        if (low[v] < low[p]) low[p] = low[v];
                        if (low[v] > disc[p] && found_cnt < 64)
                        begin
                            w = '0;
                            w.bridge_parent = p[5:0];
                            w.bridge_child = v[5:0];
                            w.bridge_valid = 1'b1;
                            w.edges_dropped = graph_overflow;
                            bridge_queue = {bridge_queue, w};
                            found_cnt++;
                        end
                    end
                end
            end
            if (found_cnt == 0)
            begin
                w = '0;
                w.edges_dropped = graph_overflow;
                bridge_queue = {bridge_queue, w};
            end
            bridge_queue[bridge_queue.size() - 1].last_result = 1'b1;
            graph_edges = 0;
            graph_overflow = 0;
        end
    endtask

    task automatic send_edge(input int a, input int b, input bit last);
        int gap;
        begin
            gap = stall_enable ? $urandom_range(0, 19) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data.edge_from_vertex <= a[5:0];
            in_data.edge_to_vertex <= b[5:0];
            in_data.last_edge <= last;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            if (graph_edges < MaxEdges)
            begin
                graph_from[graph_edges] = a[5:0];
                graph_to[graph_edges] = b[5:0];
                graph_edges++;
            end
            else
                graph_overflow = 1;
            if (last) find_bridges();
        end
    endtask

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (bridge_queue.size() != 0) @(posedge clk);
            repeat (20) @(posedge clk);
        end
    endtask

    task automatic write_vertex_count(input int n);
        begin
            wait_drained();
            cfg_we <= 1'b1;
            cfg_data <= n[6:0];
            @(posedge clk);
            cfg_we <= 1'b0;
            vertex_limit = n;
        end
    endtask

    // output stall: after each accepted word, a drawn number of stalled cycles
    always @(posedge clk)
    begin
        if (!rst_n || !stall_enable)
        begin
            out_stall <= 1'b0;
            out_hold <= 0;
        end
        else if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_stall <= (out_hold > 1);
        end
        else if (out_valid && !out_stall)
        begin
            out_draw = $urandom_range(0, 19);
            out_stall <= (out_draw > 0);
            out_hold <= out_draw;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (bridge_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word %p", out_data);
            end
            else
            begin
                out_word_t want;
                want = bridge_queue.pop_front();
                if (out_data !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", want, out_data);
                end
            end
        end
    end

    task automatic send_random_graph(input int vmax, input int n_edges);
        int a, b;
        begin
            for (int i = 0; i < n_edges; i++)
            begin
                a = $urandom_range(0, vmax);
                b = $urandom_range(0, vmax);
                if (a == b) b = (a + 1) % (vmax + 1);
                if ($urandom_range(0, 19) == 0) b = a;
                send_edge(a, b, i == n_edges - 1);
            end
        end
    endtask

    task automatic test_directed();
        begin
            // path 0-1-2 plus cycle 2-3-4: two bridges
            send_edge(0, 1, 0); send_edge(1, 2, 0); send_edge(2, 3, 0);
            send_edge(3, 4, 0); send_edge(4, 2, 1);
            // triangle, no bridges
            send_edge(0, 1, 0); send_edge(1, 2, 0); send_edge(2, 0, 1);
            // parallel edges, self loop, extremes
            send_edge(0, 63, 0); send_edge(63, 0, 0); send_edge(63, 63, 0);
            send_edge(62, 63, 1);
            // lone edge not touching the root
            send_edge(5, 6, 1);
            // reversed endpoints
            send_edge(1, 0, 1);
        end
    endtask

    task automatic test_vertex_count();
        begin
            write_vertex_count(4);
            send_edge(0, 1, 0); send_edge(1, 5, 0); send_edge(1, 3, 1);
            write_vertex_count(0);
            send_edge(0, 1, 1);
            write_vertex_count(127);
            send_edge(0, 42, 0); send_edge(42, 21, 1);
            write_vertex_count(1);
            send_edge(0, 0, 1);
            write_vertex_count(64);
        end
    endtask

    task automatic test_overflow();
        begin
            for (int i = 0; i < MaxEdges + 3; i++)
                send_edge(i % 64, (i + 1) % 64, i == MaxEdges + 2);
        end
    endtask

    task automatic test_random();
        int sent;
        int n;
        begin
            sent = 0;
            while (sent < 170)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_vertex_count($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                                  : $urandom_range(2, 64));
                n = $urandom_range(1, 12);
                send_random_graph($urandom_range(0, 1) ? 63 : $urandom_range(1, 10), n);
                sent += n;
                if (sent > 80 && sent < 95) wait_drained();
                stall_enable = ($urandom_range(0, 4) != 0);
            end
            stall_enable = 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        out_stall = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        graph_edges = 0;
        graph_overflow = 0;
        vertex_limit = 64;
        stall_enable = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_vertex_count();
        test_overflow();
        test_random();
        wait_drained();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
